>>> sv/superfasthash_32_macros.svh
// ----------------------------------------------------------------------------
// superfasthash_32 assertion macros
// concurrent assertion shorthands clocked on aclk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SUPERFASTHASH_32_MACROS_SVH
`define SUPERFASTHASH_32_MACROS_SVH

// same-cycle implication
`define SFH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SFH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/sfh_pkg.sv
// ----------------------------------------------------------------------------
// sfh_pkg
// shared widths, byte count codes, queue status type and hash mix functions
// ----------------------------------------------------------------------------
package sfh_pkg;

    localparam int WORD_W       = 32;
    localparam int COUNT_W      = 3;
    localparam int SFH_FIFO_DEPTH = 4;

    // valid byte counts of the last word
    localparam logic [COUNT_W-1:0] BYTES_NONE  = 3'd0;
    localparam logic [COUNT_W-1:0] BYTES_ONE   = 3'd1;
    localparam logic [COUNT_W-1:0] BYTES_TWO   = 3'd2;
    localparam logic [COUNT_W-1:0] BYTES_THREE = 3'd3;
    localparam logic [COUNT_W-1:0] BYTES_FULL  = 3'd4;
    localparam logic [COUNT_W-1:0] BYTES_MAX   = 3'd7;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic word_t mix_full(input word_t h_in, input word_t w);
        word_t h;
        word_t t;
        h = h_in + {16'd0, w[15:0]};
        t = {5'd0, w[31:16], 11'd0} ^ h;
        h = {h[15:0], 16'd0} ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    function automatic word_t mix_tail(input word_t h_in, input word_t w,
                                       input logic [COUNT_W-1:0] n);
        word_t h;
        h = h_in;
        case (n)
            BYTES_THREE: begin
                h = h + {16'd0, w[15:0]};
                h = h ^ (h << 16);
                h = h ^ {6'd0, w[23:16], 18'd0};
                h = h + (h >> 11);
            end
            BYTES_TWO: begin
                h = h + {16'd0, w[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            BYTES_ONE: begin
                h = h + {24'd0, w[7:0]};
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default: begin
                h = h_in;
            end
        endcase
        return h;
    endfunction

    // first half of the avalanche
    function automatic word_t aval_a(input word_t h_in);
        word_t h;
        h = h_in ^ (h_in << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        return h;
    endfunction

    // second half of the avalanche
    function automatic word_t aval_b(input word_t h_in);
        word_t h;
        h = h_in + (h_in >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

endpackage

>>> sv/sfh_fifo.sv
// ----------------------------------------------------------------------------
// sfh_fifo
// short word queue between the mixing front and the finalizing back
// ----------------------------------------------------------------------------
module sfh_fifo #(
    parameter int DEPTH = sfh_pkg::SFH_FIFO_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  sfh_pkg::word_t      wdata,
    input  logic                pop,
    output sfh_pkg::word_t      rdata,
    output sfh_pkg::fifo_stat_t stat
);
    import sfh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    word_t              mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rdata      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> sv/sfh_front.sv
// ----------------------------------------------------------------------------
// sfh_front
// accepts words, keeps the running hash and queues the pre-avalanche value
// ----------------------------------------------------------------------------
module sfh_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  sfh_pkg::word_t                s_axis_tdata,   // data_word
    input  logic [sfh_pkg::COUNT_W-1:0]   s_axis_tuser,   // byte_count
    input  logic                          s_axis_tlast,   // last_of_message
    input  sfh_pkg::fifo_stat_t           q_stat,
    output logic                          q_push,
    output sfh_pkg::word_t                q_wdata
);
    import sfh_pkg::*;

    word_t hash_reg, hash_next;
    word_t full_mix;
    logic  accept;

    assign s_axis_tready = !q_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign full_mix      = mix_full(hash_reg, s_axis_tdata);
    assign q_push        = accept && s_axis_tlast;

    always_comb begin
        case (s_axis_tuser) inside
            [BYTES_FULL:BYTES_MAX]: q_wdata = full_mix;
            default:                q_wdata = mix_tail(hash_reg, s_axis_tdata, s_axis_tuser);
        endcase
    end

    always_comb begin
        hash_next = hash_reg;
        if (accept) begin
            // a message ends: start the next one from zero
            hash_next = s_axis_tlast ? '0 : full_mix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= '0;
        end else begin
            hash_reg <= hash_next;
        end
    end

endmodule

>>> sv/sfh_back.sv
// ----------------------------------------------------------------------------
// sfh_back
// two-stage avalanche finalization with a registered result word
// ----------------------------------------------------------------------------
module sfh_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  sfh_pkg::fifo_stat_t q_stat,
    input  sfh_pkg::word_t      q_rdata,
    output logic                q_pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output sfh_pkg::word_t      m_axis_tdata    // hash_value
);
    import sfh_pkg::*;

    logic  mid_valid_reg, mid_valid_next;
    word_t mid_data_reg;
    logic  out_valid_reg, out_valid_next;
    word_t out_data_reg;
    logic  out_free, mid_free;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign mid_free = !mid_valid_reg || out_free;
    assign q_pop    = !q_stat.empty && mid_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb begin
        mid_valid_next = mid_free ? q_pop : mid_valid_reg;
        out_valid_next = out_free ? mid_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            mid_data_reg <= aval_a(q_rdata);
        end
        if (out_free && mid_valid_reg) begin
            out_data_reg <= aval_b(mid_data_reg);
        end
    end

endmodule

>>> sv/superfasthash_32.sv
// ----------------------------------------------------------------------------
// superfasthash_32
// streaming 32-bit superfasthash: word mix in front, avalanche in back
// ----------------------------------------------------------------------------
//  channel   dir  tdata          tuser        tlast
//  s_axis    in   data_word[31:0] byte_count[2:0] last_of_message
//  m_axis    out  hash_value[31:0] -            -
//
//  one word per cycle while the queue has room; the running hash updates in the
//  cycle a word is taken, so back-to-back words of one message need no bubbles.
//  the last word is queued at its accepting edge; m_axis_tvalid rises after
//  the avalanche stage and the output register at the earliest.
//  reset clears the running hash, queue and valid flags.
//  s_axis_tready drops only when the result queue is full behind a stalled m_axis.
// ----------------------------------------------------------------------------
module superfasthash_32 #(
    parameter int FIFO_DEPTH = sfh_pkg::SFH_FIFO_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,   // data_word
    input  logic [sfh_pkg::COUNT_W-1:0] s_axis_tuser,   // byte_count
    input  logic                        s_axis_tlast,   // last_of_message
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata    // hash_value
);
    import sfh_pkg::*;

    fifo_stat_t q_stat;
    logic       q_push, q_pop;
    word_t      q_wdata, q_rdata;

    sfh_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    sfh_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    sfh_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_stat        (q_stat),
        .q_rdata       (q_rdata),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> sv/sfh_checker.sv
// ----------------------------------------------------------------------------
// sfh_checker
// port-level checks on superfasthash_32, bound to the top level
// ----------------------------------------------------------------------------
`include "superfasthash_32_macros.svh"

module sfh_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // a held result word keeps its value
    `SFH_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result word dropped or changed while stalled")

    // input backpressure only follows an output stall
    `SFH_ASSERT_NOW(a_bp_cause, !s_axis_tready,
        $past(m_axis_tvalid && !m_axis_tready), "input stalled without output stall")

    // nothing is offered right after reset
    `SFH_ASSERT_NOW(a_reset_idle, $rose(aresetn),
        !m_axis_tvalid && s_axis_tready, "block not idle after reset")

endmodule

bind superfasthash_32 sfh_checker u_sfh_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> bench/tb_superfasthash_32.sv
// ----------------------------------------------------------------------------
// tb_superfasthash_32
// Streams messages of random length and content into the hash block and
// checks every emitted hash against a cycle-free model of the word mix, tail
// mix and avalanche, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module tb_superfasthash_32;

    timeunit 1ns;
    timeprecision 1ps;

    import sfh_pkg::*;

    localparam int ITEM_TARGET    = 1450;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                aclk;
    logic                aresetn;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [31:0]         s_axis_tdata;   // data_word
    logic [COUNT_W-1:0]  s_axis_tuser;   // byte_count
    logic                s_axis_tlast;   // last_of_message
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [31:0]         m_axis_tdata;   // hash_value

    word_t pending_hashes[$];
    word_t hash_acc;
    int    errors;
    int    words_sent;
    bit    quiet_mode;
    int    stuck_cycles;

    superfasthash_32 u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------- hash model ----------------

    function automatic word_t fold_word(input word_t h, input word_t w);
        word_t acc;
        word_t upper;
        upper = {16'd0, w[31:16]};
        acc = h + {16'd0, w[15:0]};
        acc = (acc << 16) ^ (upper << 11) ^ acc;
        return acc + (acc >> 11);
    endfunction

    function automatic word_t fold_tail(input word_t h, input word_t w,
                                        input logic [COUNT_W-1:0] n);
        word_t acc;
        acc = h;
        if (n == BYTES_THREE) begin
            acc = acc + {16'd0, w[15:0]};
            acc = acc ^ (acc << 16);
            acc = acc ^ ({24'd0, w[23:16]} << 18);
            acc = acc + (acc >> 11);
        end else if (n == BYTES_TWO) begin
            acc = acc + {16'd0, w[15:0]};
            acc = acc ^ (acc << 11);
            acc = acc + (acc >> 17);
        end else if (n == BYTES_ONE) begin
            acc = acc + {24'd0, w[7:0]};
            acc = acc ^ (acc << 10);
            acc = acc + (acc >> 1);
        end
        return acc;
    endfunction

    function automatic word_t avalanche(input word_t h);
        word_t acc;
        acc = h ^ (h << 3);
        acc = acc + (acc >> 5);
        acc = acc ^ (acc << 4);
        acc = acc + (acc >> 17);
        acc = acc ^ (acc << 25);
        return acc + (acc >> 6);
    endfunction

    // advance the model by one accepted word
    task automatic track_word(input word_t data, input logic [COUNT_W-1:0] cnt,
                              input bit last);
        logic [COUNT_W-1:0] n;
        word_t h;
        n = (cnt > BYTES_FULL) ? BYTES_FULL : cnt;
        if (!last) begin
            hash_acc = fold_word(hash_acc, data);
        end else begin
            h = (n == BYTES_FULL) ? fold_word(hash_acc, data)
                                  : fold_tail(hash_acc, data, n);
            pending_hashes.push_back(avalanche(h));
            hash_acc = '0;
        end
    endtask

    // ---------------- stimulus helpers ----------------

    function automatic int unsigned idle_len();
        int unsigned r;
        if (quiet_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic word_t rand_word();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic send_word(input word_t data, input logic [COUNT_W-1:0] cnt,
                             input bit last);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= cnt;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        track_word(data, cnt, last);
        words_sent++;
    endtask

    // body words are full unless noisy, where the count may be junk
    task automatic send_message(input int unsigned body_len, input bit noisy);
        logic [COUNT_W-1:0] cnt;
        for (int unsigned i = 0; i < body_len; i++) begin
            cnt = (noisy && $urandom_range(0, 1)) ? COUNT_W'($urandom_range(0, 7))
                                                   : BYTES_FULL;
            send_word(rand_word(), cnt, 1'b0);
        end
        cnt = noisy ? COUNT_W'($urandom_range(0, 7)) : COUNT_W'($urandom_range(0, 4));
        send_word(rand_word(), cnt, 1'b1);
    endtask

    // ---------------- tests ----------------

    task automatic test_single_word_messages();
        send_word(32'hDEAD_BEEF, BYTES_NONE, 1'b1);   // empty message
        send_word(32'hFFFF_FFFF, BYTES_ONE, 1'b1);
        send_word(32'hFFFF_FFFF, BYTES_TWO, 1'b1);
        send_word(32'hFFFF_FFFF, BYTES_THREE, 1'b1);
        send_word(32'hFFFF_FFFF, BYTES_FULL, 1'b1);
        send_word(32'h0000_0000, BYTES_FULL, 1'b1);
        // bytes past the count must not leak into the tail mix
        send_word(32'hA5A5_A53C, BYTES_ONE, 1'b1);
        send_word(32'h5A5A_C3C3, BYTES_TWO, 1'b1);
        send_word(32'hFF12_3456, BYTES_THREE, 1'b1);
    endtask

    task automatic test_odd_byte_counts();
        send_word(32'hFFFF_FFFF, BYTES_FULL, 1'b0);
        send_word(32'h0000_0000, BYTES_THREE, 1'b1);
        // counts on body words are ignored, counts above four mean four
        send_word(32'h1234_5678, BYTES_NONE, 1'b0);
        send_word(32'h8765_4321, BYTES_MAX, 1'b0);
        send_word(32'hCAFE_F00D, 3'd5, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd6, 1'b1);
        send_word(32'h0000_0000, BYTES_MAX, 1'b1);
        send_word(32'h0F0F_0F0F, BYTES_ONE, 1'b0);
        send_word(32'hF0F0_F0F0, BYTES_THREE, 1'b0);
        send_word(32'h7FFF_FFFF, BYTES_NONE, 1'b1);   // words then empty tail
    endtask

    task automatic test_back_to_back();
        quiet_mode = 1'b1;
        for (int i = 0; i < 12; i++)
            send_message($urandom_range(0, 8), 1'b0);
        quiet_mode = 1'b0;
    endtask

    task automatic test_random_messages();
        int unsigned r;
        int unsigned len;
        while (words_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(0, 4);
            else if (r < 95)
                len = $urandom_range(5, 16);
            else
                len = $urandom_range(17, 64);
            send_message(len, $urandom_range(0, 9) == 0);
        end
    endtask

    // ---------------- result side ----------------

    initial begin : sink_ready
        int unsigned stall;
        m_axis_tready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = idle_len();
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_hashes.size() == 0) begin
                $display("%0t: unexpected hash word, expected none, actual %h",
                         $time, m_axis_tdata);
                errors++;
            end else if (m_axis_tdata !== pending_hashes[0]) begin
                $display("%0t: hash_value mismatch, expected %h, actual %h",
                         $time, pending_hashes[0], m_axis_tdata);
                errors++;
                void'(pending_hashes.pop_front());
            end else begin
                void'(pending_hashes.pop_front());
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, %0d hashes outstanding", $time,
                     pending_hashes.size());
            $display("tb_superfasthash_32 NOT OK");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        errors       = 0;
        words_sent   = 0;
        quiet_mode   = 1'b0;
        hash_acc     = '0;
        stuck_cycles = 0;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_word_messages();
        test_odd_byte_counts();
        test_back_to_back();
        test_random_messages();

        s_axis_tvalid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("tb_superfasthash_32 OK");
        else
            $display("tb_superfasthash_32 NOT OK");
        $finish;
    end

endmodule
